// ----- rtl/chacha_packet_payload_cipher_assert.svh -----
// assertion macros for the chacha payload cipher
// included by the top level; no other dependencies
`ifndef CHACHA_PACKET_PAYLOAD_CIPHER_ASSERT_SVH
`define CHACHA_PACKET_PAYLOAD_CIPHER_ASSERT_SVH
`ifndef SYNTH
`define CPC_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define CPC_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CPC_ASSERT_IMPL(label, a, c)
`define CPC_ASSERT_NEXT(label, a, c)
`endif
`endif

// ----- rtl/cpc_pkg.sv -----
// shared types and constants for the chacha payload cipher
// no dependencies
`timescale 1ns / 1ps
package cpc_pkg;
  localparam int PACKET_SIZE_BITS = 16;
  localparam int BLOCK_BYTES = 512 / 8;
  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KEY3 = 3'd3;
  localparam logic [2:0] CFG_NONCE = 3'd4;
  localparam logic [2:0] CFG_LONG = 3'd5;
  localparam logic [2:0] CFG_ROUNDS = 3'd6;
  // "expand 32-byte k" and "expand 16-byte k"
  localparam logic [127:0] SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
  localparam logic [127:0] TAU = {32'h6b206574, 32'h79622d36, 32'h3120646e, 32'h61707865};

  typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL, ST_OUT} state_t;

  typedef struct packed {
    logic load;     // latch word; at block start also load initial state
    logic half;     // run one half round (column or diagonal)
    logic diag;     // diagonal half round when set
    logic finish;   // add init state into keystream buffer
    logic emit;     // compute result into output register
  } cmd_t;

  typedef struct packed {
    logic gen;      // word starts a block
    logic [5:0] halves; // half rounds to run
  } stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int c);
    rotl = (v << c) | (v >> (32 - c));
  endfunction

  function automatic logic [127:0] qr(input logic [127:0] x);
    logic [31:0] a, b, c, d;
    a = x[31:0]; b = x[63:32]; c = x[95:64]; d = x[127:96];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    qr = {d, c, b, a};
  endfunction
endpackage

// ----- rtl/cpc_ctrl.sv -----
// controller state machine for the chacha payload cipher
// depends on cpc_pkg
`timescale 1ns / 1ps
module cpc_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  input  cpc_pkg::stat_t stat,
  output cpc_pkg::cmd_t cmd
);
  import cpc_pkg::*;
  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  // accept in idle while the output register is free or being drained
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          cnt_nxt = '0;
          state_nxt = stat.gen ? ST_ROUND : ST_OUT;
        end
      end
      ST_ROUND: begin
        if (cnt_r == stat.halves) begin
          state_nxt = ST_FINAL;
        end else begin
          cmd.half = 1'b1;
          cmd.diag = cnt_r[0];
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_FINAL: begin
        cmd.finish = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/cpc_datapath.sv -----
// datapath: config registers, position, counter, round state, keystream
// depends on cpc_pkg
`timescale 1ns / 1ps
module cpc_datapath (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_write_enable,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [63:0] in_payload_word,
  input  logic [15:0] in_packet_bytes,
  input  logic in_packet_first,
  input  logic in_packet_last,
  input  cpc_pkg::cmd_t cmd,
  output cpc_pkg::stat_t stat,
  output logic [63:0] out_cipher_word,
  output logic out_cipher_last
);
  import cpc_pkg::*;
  localparam int PB = PACKET_SIZE_BITS;

  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_r;
  logic long_r;
  logic [4:0] rounds_r;
  logic [63:0] ctr_r;
  logic [PB-1:0] pos_r;
  logic [511:0] work_r, init_r, ks_r;
  logic [63:0] word_r;
  logic last_r, full_r;
  logic [2:0] widx_r;
  logic [63:0] out_word_r;
  logic out_last_r;

  logic [PB-1:0] pos_cur, start;
  logic [PB:0] end_sum;
  logic [PB-1:0] size;
  logic full, gen;
  logic [63:0] ctr_cur;
  logic [63:0] k2, k3;
  logic [511:0] init_v, work_nxt;
  logic [31:0] w [16];
  logic [127:0] q0, q1, q2, q3;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0; key1_r <= '0; key2_r <= '0; key3_r <= '0;
      nonce_r <= '0; long_r <= 1'b0; rounds_r <= 5'd20;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_KEY0: key0_r <= cfg_data;
        CFG_KEY1: key1_r <= cfg_data;
        CFG_KEY2: key2_r <= cfg_data;
        CFG_KEY3: key3_r <= cfg_data;
        CFG_NONCE: nonce_r <= cfg_data;
        CFG_LONG: long_r <= cfg_data[0];
        CFG_ROUNDS: rounds_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // block position and fullness of the incoming word
  assign pos_cur = in_packet_first ? '0 : pos_r;
  assign ctr_cur = in_packet_first ? '0 : ctr_r;
  assign size = in_packet_bytes[PB-1:0];
  assign start = {pos_cur[PB-1:6], 6'd0};
  assign end_sum = {1'b0, start} + (PB+1)'(BLOCK_BYTES);
  assign full = end_sum <= {1'b0, size};
  assign gen = (pos_cur[5:0] == 6'd0);
  assign stat.gen = gen;
  // double rounds rounded up, kept at 5 bits so 31 rounds gives 16
  assign stat.halves = {({1'b0, rounds_r[4:1]} + {4'd0, rounds_r[0]}), 1'b0};

  // initial block state
  assign k2 = long_r ? key2_r : key0_r;
  assign k3 = long_r ? key3_r : key1_r;
  assign init_v = {nonce_r, ctr_cur, k3, k2, key1_r, key0_r, long_r ? SIGMA : TAU};

  // one column or diagonal half round
  always_comb begin
    for (int i = 0; i < 16; i++) w[i] = work_r[32*i +: 32];
    if (!cmd.diag) begin
      q0 = qr({w[12], w[8], w[4], w[0]});
      q1 = qr({w[13], w[9], w[5], w[1]});
      q2 = qr({w[14], w[10], w[6], w[2]});
      q3 = qr({w[15], w[11], w[7], w[3]});
      work_nxt = {q3[127:96], q2[127:96], q1[127:96], q0[127:96],
                  q3[95:64], q2[95:64], q1[95:64], q0[95:64],
                  q3[63:32], q2[63:32], q1[63:32], q0[63:32],
                  q3[31:0], q2[31:0], q1[31:0], q0[31:0]};
    end else begin
      q0 = qr({w[15], w[10], w[5], w[0]});
      q1 = qr({w[12], w[11], w[6], w[1]});
      q2 = qr({w[13], w[8], w[7], w[2]});
      q3 = qr({w[14], w[9], w[4], w[3]});
      work_nxt = {q0[127:96], q3[127:96], q2[127:96], q1[127:96],
                  q1[95:64], q0[95:64], q3[95:64], q2[95:64],
                  q2[63:32], q1[63:32], q0[63:32], q3[63:32],
                  q3[31:0], q2[31:0], q1[31:0], q0[31:0]};
    end
  end

  // position, counter, round state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
      pos_r <= '0;
    end else if (cmd.load) begin
      pos_r <= pos_cur + PB'(8);
      ctr_r <= (gen && full) ? ctr_cur + 64'd1 : ctr_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_payload_word;
      last_r <= in_packet_last;
      full_r <= full;
      widx_r <= pos_cur[5:3];
      if (gen) begin
        work_r <= init_v;
        init_r <= init_v;
      end
    end else if (cmd.half) begin
      work_r <= work_nxt;
    end
    if (cmd.finish) begin
      for (int i = 0; i < 16; i++)
        ks_r[32*i +: 32] <= work_r[32*i +: 32] + init_r[32*i +: 32];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r <= full_r ? (word_r ^ ks_r[64*widx_r +: 64]) : word_r;
      out_last_r <= last_r;
    end
  end
  assign out_cipher_word = out_word_r;
  assign out_cipher_last = out_last_r;
endmodule

// ----- rtl/chacha_packet_payload_cipher.sv -----
// chacha payload cipher: a word at block start runs rounds/2 rounded up
// double rounds as two half rounds each, one per cycle, after a load and
// before a finish and an emit; other words take only a load and an emit
// reset synchronous active low: clears config to defaults, counter, position
// top level; depends on cpc_pkg, cpc_ctrl, cpc_datapath and the assert header
`timescale 1ns / 1ps
`include "chacha_packet_payload_cipher_assert.svh"
module chacha_packet_payload_cipher (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_write_enable,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [63:0] in_payload_word,
  input  logic [15:0] in_packet_bytes,
  input  logic in_packet_first,
  input  logic in_packet_last,
  output logic out_valid,
  input  logic out_ready,
  output logic [63:0] out_cipher_word,
  output logic out_cipher_last
);
  import cpc_pkg::*;
  cmd_t cmd;
  stat_t stat;

  // controller
  cpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .out_valid(out_valid), .stat(stat), .cmd(cmd)
  );

  // datapath
  cpc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_payload_word(in_payload_word),
    .in_packet_bytes(in_packet_bytes), .in_packet_first(in_packet_first),
    .in_packet_last(in_packet_last), .cmd(cmd), .stat(stat),
    .out_cipher_word(out_cipher_word), .out_cipher_last(out_cipher_last)
  );

  // checks
  `CPC_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.half, cmd.finish, cmd.emit}))
  `CPC_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid)
  `CPC_ASSERT_IMPL(a_no_accept_busy, cmd.half || cmd.finish, !in_ready)
endmodule
